FILE: sv/olad_pkg.sv
// Package: shared constants, status codes and state type for the ordered list block.
`timescale 1ns / 1ps
package olad_pkg;

	localparam int CAPACITY = 16;
	localparam int DATA_W   = 32;

	localparam logic OP_APPEND = 1'b0;
	localparam logic OP_DELETE = 1'b1;

	typedef enum logic [2:0] {
		ST_APPENDED      = 3'd0,
		ST_HEAD_REMOVED  = 3'd1,
		ST_LATER_REMOVED = 3'd2,
		ST_NOT_FOUND     = 3'd3,
		ST_EMPTY         = 3'd4,
		ST_FULL          = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_SHIFT,
		S_RESULT
	} state_t;

endpackage

FILE: sv/olad_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
`timescale 1ns / 1ps
module olad_ram #(
	parameter int WIDTH  = olad_pkg::DATA_W,
	parameter int DEPTH  = olad_pkg::CAPACITY,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

FILE: sv/ordered_list_append_delete.sv
// Top level: bounded ordered list of signed 32-bit values with append and delete.
`timescale 1ns / 1ps
// Ordered list of up to CAPACITY signed 32-bit values, held in one RAM from
// head (address 0) to tail. Each input transaction carries op and value in
// s_tdata: op 0 appends value at the tail, op 1 deletes the first entry equal
// to value and moves every later entry one place toward the head. Every
// transaction yields exactly one result transaction with a status code
// (appended, head removed, later entry removed, not found, empty, full), the
// empty flag and the entry count after the operation, the count taken modulo
// 32. One transaction is worked at a time; s_tready is high only while the
// block is idle, and a finished result waits in an output register so the
// next transaction can be taken while the result is still pending.
// From the accepting edge, an append, a rejected append and a delete on an
// empty list go straight to the result state; any other delete scans the
// entries from the head through the single RAM read port, one per cycle, each
// compare trailing its read through the registered read data. After the scan
// stops at a match, each later entry is read once and written one place down.
// The result register is loaded only while it is free. s_tready rises again
// at the edge that loads the result register. No clearing pass is needed
// after reset: entries beyond the count are never read.
module ordered_list_append_delete #(
	parameter int CAPACITY = olad_pkg::CAPACITY
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [0] op, [32:1] value, [39:33] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [2:0] status, [3] is_empty, [8:4] entry_count, [15:9] zero
);

	import olad_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

	state_t state_q, state_d;

	logic [CW-1:0]     count_q;     // entries held
	logic [CW-1:0]     ptr_q;       // next RAM address to read
	logic [CW-1:0]     idx_s1;      // address whose data is on rd_data
	logic              idx_valid_s1;
	logic              head_q;      // matched entry sat at the head
	logic [DATA_W-1:0] value_q;
	status_t           status_q;
	logic              m_tvalid_q;
	logic [15:0]       m_tdata_q;

	logic              s_op;
	logic [DATA_W-1:0] s_value;
	logic              s_acc;
	logic              more;        // entries left to read
	logic              issue;
	logic              match;
	logic              out_free;
	logic [CW-1:0]     shift_dst;

	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [DATA_W-1:0] wr_data;
	logic [DATA_W-1:0] rd_data;

	assign s_op      = s_tdata[0];
	assign s_value   = s_tdata[32:1];
	assign s_tready  = (state_q == S_IDLE);
	assign s_acc     = s_tvalid && s_tready;
	assign more      = (ptr_q < count_q);
	assign out_free  = !m_tvalid_q || m_tready;
	assign match     = (state_q == S_SEARCH) && idx_valid_s1 && (rd_data == value_q);
	assign shift_dst = idx_s1 - CW'(1);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	olad_ram #(
		.WIDTH (DATA_W),
		.DEPTH (CAPACITY),
		.ADDR_W(AW)
	) u_list_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(ptr_q[AW-1:0]),
		.rd_data(rd_data)
	);

	// Next state, RAM write port and read issue.
	always_comb begin
		state_d = state_q;
		issue   = 1'b0;
		wr_en   = 1'b0;
		wr_addr = shift_dst[AW-1:0];
		wr_data = rd_data;
		case (state_q)
			S_IDLE: begin
				if (s_acc) begin
					if (s_op == OP_APPEND) begin
						// write the new tail right away unless the list is full
						if (count_q < CAP_CNT) begin
							wr_en   = 1'b1;
							wr_addr = count_q[AW-1:0];
							wr_data = s_value;
						end
						state_d = S_RESULT;
					end else if (count_q == '0) begin
						state_d = S_RESULT;
					end else begin
						state_d = S_SEARCH;
					end
				end
			end
			S_SEARCH: begin
				// read one entry per cycle, compare it the cycle after
				issue = more && !match;
				if (match) begin
					state_d = S_SHIFT;
				end else if (!idx_valid_s1 && !more) begin
					state_d = S_RESULT;
				end
			end
			S_SHIFT: begin
				// read entry j, write it to j-1 in the cycle after
				issue = more;
				if (idx_valid_s1) begin
					wr_en = 1'b1;
				end
				if (!more && !idx_valid_s1) begin
					state_d = S_RESULT;
				end
			end
			S_RESULT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			ptr_q        <= '0;
			idx_valid_s1 <= 1'b0;
			m_tvalid_q   <= 1'b0;
		end else begin
			state_q      <= state_d;
			idx_valid_s1 <= issue;
			if (issue) begin
				ptr_q <= ptr_q + CW'(1);
			end
			// load a finished result, else drop the one just taken
			if (state_q == S_RESULT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					ptr_q <= '0;
					if (s_acc && s_op == OP_APPEND && count_q < CAP_CNT) begin
						count_q <= count_q + CW'(1);
					end
				end
				S_SEARCH: begin
					// restart reading just past the matched entry
					if (match) begin
						ptr_q <= idx_s1 + CW'(1);
					end
				end
				S_SHIFT: begin
					if (!more && !idx_valid_s1) begin
						count_q <= count_q - CW'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		idx_s1 <= ptr_q;
		case (state_q)
			S_IDLE: begin
				if (s_acc) begin
					value_q <= s_value;
					if (s_op == OP_APPEND) begin
						status_q <= (count_q < CAP_CNT) ? ST_APPENDED : ST_FULL;
					end else begin
						status_q <= ST_EMPTY;
					end
				end
			end
			S_SEARCH: begin
				if (match) begin
					head_q <= (idx_s1 == '0);
				end else if (!idx_valid_s1 && !more) begin
					status_q <= ST_NOT_FOUND;
				end
			end
			S_SHIFT: begin
				if (!more && !idx_valid_s1) begin
					status_q <= head_q ? ST_HEAD_REMOVED : ST_LATER_REMOVED;
				end
			end
			S_RESULT: begin
				// hold the result until the output register is free
				if (out_free) begin
					m_tdata_q <= {7'd0, 5'(count_q), (count_q == '0), status_q};
				end
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_CNT)
		else $error("entry count exceeds capacity");

	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && s_op == OP_APPEND && count_q < CAP_CNT)
		|=> count_q == $past(count_q) + CW'(1))
		else $error("append did not advance the entry count");

	a_write_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && state_q == S_SHIFT) |-> (CW'(wr_addr) + CW'(1) < count_q))
		else $error("shift write outside the list");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESULT && status_q == ST_FULL) |-> (count_q == CAP_CNT))
		else $error("full status with room left");
`endif

endmodule

FILE: verif/testbench.sv
// Testbench: directed and random append/delete traffic checked against a list predictor.
`timescale 1ns / 1ps
module testbench;
	import olad_pkg::*;

	localparam int CAP = olad_pkg::CAPACITY;

	// One pending input transaction and the sender gap that precedes it
	typedef struct {
		logic        op;
		logic [31:0] value;
		int          gap;
		bit          wait_drain;
	} list_op_t;

	// Result fields expected for one accepted transaction
	typedef struct {
		status_t    status;
		logic       is_empty;
		logic [4:0] entry_count;
	} list_outcome_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata  = '0;   // [0] op, [32:1] value, [39:33] zero
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;         // [2:0] status, [3] is_empty, [8:4] entry_count, [15:9] zero

	list_op_t      ops_to_send[$];
	list_outcome_t outcomes_due[$];

	// Predictor state: the list from head (index 0) to tail
	logic [31:0] model_values[CAP];
	int unsigned model_count = 0;

	// Generator view of the list, used only to aim deletes at held values
	logic [31:0] gen_list[$];

	int gap_left     = 0;
	int ready_wait   = 0;
	int results_seen = 0;
	int mismatches   = 0;

	ordered_list_append_delete #(
		.CAPACITY(CAP)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Hold reset, then release it once
	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Apply one accepted transaction to the predictor and queue the result it must produce.
	task automatic predict_list_op(input logic op, input logic [31:0] value);
		list_outcome_t outcome;
		int            hit;
		hit = -1;
		if (op == OP_APPEND) begin
			if (model_count >= CAP) begin
				outcome.status = ST_FULL;
			end else begin
				model_values[model_count] = value;
				model_count++;
				outcome.status = ST_APPENDED;
			end
		end else if (model_count == 0) begin
			outcome.status = ST_EMPTY;
		end else begin
			// Find the matching entry nearest the head; duplicates further back stay
			for (int i = 0; i < model_count; i++) begin
				if (hit < 0 && model_values[i] == value)
					hit = i;
			end
			if (hit < 0) begin
				outcome.status = ST_NOT_FOUND;
			end else begin
				// Close the gap so the remaining order is kept
				for (int i = hit; i + 1 < model_count; i++)
					model_values[i] = model_values[i + 1];
				model_count--;
				outcome.status = (hit == 0) ? ST_HEAD_REMOVED : ST_LATER_REMOVED;
			end
		end
		outcome.is_empty    = (model_count == 0);
		outcome.entry_count = model_count[4:0];
		outcomes_due.push_back(outcome);
	endtask

	// Queue one input transaction and track the list the generator expects.
	task automatic queue_op(input logic op, input logic [31:0] value, input bit wait_drain);
		list_op_t item;
		int       hit;
		hit             = -1;
		item.op         = op;
		item.value      = value;
		item.wait_drain = wait_drain;
		// Every fourth stretch of 150 transactions goes back to back
		item.gap = ((ops_to_send.size() / 150) % 4 == 2) ? 0 : $urandom_range(9, 0);
		ops_to_send.push_back(item);
		if (op == OP_APPEND) begin
			if (gen_list.size() < CAP)
				gen_list.push_back(value);
		end else begin
			foreach (gen_list[i])
				if (hit < 0 && gen_list[i] == value)
					hit = i;
			if (hit >= 0)
				gen_list.delete(hit);
		end
	endtask

	// Mix full-range values with a small pool and the extremes so duplicates show up.
	function automatic logic [31:0] pick_value();
		case ($urandom_range(3, 0))
			2: return 32'($signed($urandom_range(6, 0)) - 3);
			3: begin
				case ($urandom_range(3, 0))
					0: return 32'h7fff_ffff;
					1: return 32'h8000_0000;
					2: return 32'h0000_0000;
					default: return 32'hffff_ffff;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	// Driver: offer the head of ops_to_send after its gap, advance on every accepted
	// transaction. Compute the next valid first so it takes one assignment per edge.
	always @(posedge clk or negedge arst_n) begin : drive
		logic next_valid;
		int   next_gap;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			gap_left <= 0;
		end else begin
			next_valid = s_tvalid;
			next_gap   = gap_left;
			if (s_tvalid && s_tready) begin
				predict_list_op(s_tdata[0], s_tdata[32:1]);
				void'(ops_to_send.pop_front());
				next_valid = 1'b0;
				next_gap   = (ops_to_send.size() != 0) ? ops_to_send[0].gap : 0;
			end
			if (!next_valid) begin
				if (next_gap != 0) begin
					next_gap--;
				end else if (ops_to_send.size() != 0 &&
						!(ops_to_send[0].wait_drain && outcomes_due.size() != 0)) begin
					// A draining transaction holds back until every result is in
					next_valid = 1'b1;
					s_tdata    <= {7'b0, ops_to_send[0].value, ops_to_send[0].op};
				end
			end
			s_tvalid <= next_valid;
			gap_left <= next_gap;
		end
	end

	// Monitor: check every accepted result against the oldest expectation, then
	// draw how long to drop m_tready before the next one.
	always @(posedge clk or negedge arst_n) begin : collect
		list_outcome_t due;
		int            next_wait;
		if (!arst_n) begin
			m_tready   <= 1'b0;
			ready_wait <= 0;
		end else begin
			next_wait = (ready_wait != 0) ? ready_wait - 1 : 0;
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (outcomes_due.size() == 0) begin
					$error("result with no transaction outstanding: m_tdata %h", m_tdata);
					mismatches++;
				end else begin
					due = outcomes_due.pop_front();
					if (m_tdata[2:0] !== due.status) begin
						$error("status: expected %0d got %0d", due.status, m_tdata[2:0]);
						mismatches++;
					end
					if (m_tdata[3] !== due.is_empty) begin
						$error("is_empty: expected %0d got %0d", due.is_empty, m_tdata[3]);
						mismatches++;
					end
					if (m_tdata[8:4] !== due.entry_count) begin
						$error("entry_count: expected %0d got %0d", due.entry_count,
							m_tdata[8:4]);
						mismatches++;
					end
				end
				// Long hold-offs let the block fill up and stall its input side
				if (results_seen == 300 || results_seen == 1100)
					next_wait = 400;
				else if ((results_seen / 170) % 4 == 3)
					next_wait = 0;
				else
					next_wait = $urandom_range(9, 0);
			end
			ready_wait <= next_wait;
			m_tready   <= (next_wait == 0);
		end
	end

	initial begin : stimulus
		bit          fill_bias;
		logic        op;
		logic [31:0] value;
		fill_bias = 1'b0;

		// Directed: delete on empty, extremes, duplicates, head, later and tail removal,
		// a miss, then fill to capacity and push past it.
		queue_op(OP_DELETE, 32'h0000_0000, 1'b0);
		queue_op(OP_APPEND, 32'h7fff_ffff, 1'b0);
		queue_op(OP_APPEND, 32'h8000_0000, 1'b0);
		queue_op(OP_APPEND, 32'h0000_0005, 1'b0);
		queue_op(OP_APPEND, 32'hffff_ffff, 1'b0);
		queue_op(OP_APPEND, 32'h0000_0005, 1'b0);
		queue_op(OP_APPEND, 32'h0000_0000, 1'b0);
		queue_op(OP_DELETE, 32'h0000_0005, 1'b0);
		queue_op(OP_DELETE, 32'h7fff_ffff, 1'b0);
		queue_op(OP_DELETE, 32'h0000_3039, 1'b0);
		queue_op(OP_DELETE, 32'h0000_0000, 1'b0);
		while (gen_list.size() < CAP)
			queue_op(OP_APPEND, $urandom, 1'b0);
		queue_op(OP_APPEND, 32'h5555_aaaa, 1'b0);
		queue_op(OP_APPEND, 32'haaaa_5555, 1'b0);

		// Random: swing between filling and draining phases, aim most deletes at held
		// values, and pause twice until every result is back.
		for (int n = 0; n < 1800; n++) begin
			if (n % 200 == 0)
				fill_bias = ~fill_bias;
			op = ($urandom_range(9, 0) < (fill_bias ? 7 : 3)) ? OP_APPEND : OP_DELETE;
			if (op == OP_DELETE && gen_list.size() != 0 && $urandom_range(3, 0) != 0)
				value = gen_list[$urandom_range(gen_list.size() - 1, 0)];
			else
				value = pick_value();
			queue_op(op, value, (n == 600 || n == 1250));
		end

		// Drain, then let the pipeline settle before the verdict
		while (ops_to_send.size() != 0 || outcomes_due.size() != 0)
			@(posedge clk);
		repeat (4 * CAP + 10) @(posedge clk);
		if (mismatches == 0) begin
			$display("ordered_list_append_delete: match");
		end else begin
			$display("ordered_list_append_delete: mismatch");
		end
		$finish;
	end

	// Hard stop well past the slowest correct run
	initial begin
		#2_000_000;
		$display("ordered_list_append_delete: mismatch");
		$finish;
	end

endmodule
